/* src/mlta_pkg.sv */
// mlta_pkg: types, codes and constants for the address table with aging
// shared by mlta_cell, mlta_ctrl and mac_learning_table_aging
`default_nettype none
package mlta_pkg;

	localparam int TableEntriesDef = 1024;
	localparam int PortCountDef    = 16;

	localparam int MacW   = 48;
	localparam int PortsW = 16;
	localparam int StampW = 32;
	localparam int AgeW   = 16;
	localparam int LimW   = 11;

	localparam logic [MacW-1:0] StpMac = 48'h0180C2000000;

	typedef enum logic [2:0] {
		OP_LEARN    = 3'd0,
		OP_LOOKUP   = 3'd1,
		OP_ADD      = 3'd2,
		OP_STATIC   = 3'd3,
		OP_REMOVE   = 3'd4,
		OP_RM_PORT  = 3'd5,
		OP_FLUSH    = 3'd6,
		OP_NOP      = 3'd7
	} op_t;

	localparam logic [1:0] KIND_DYN    = 2'd0;
	localparam logic [1:0] KIND_STATIC = 2'd1;
	localparam logic [1:0] KIND_GROUP  = 2'd2;
	localparam logic [1:0] KIND_RSVD   = 2'd3;

	localparam logic [1:0] CLASS_NONE = 2'd0;
	localparam logic [1:0] CLASS_STP  = 2'd1;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_MISSING = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	localparam logic [1:0] REG_NORMAL_AGE = 2'd0;
	localparam logic [1:0] REG_FAST_AGE   = 2'd1;
	localparam logic [1:0] REG_FAST_ON    = 2'd2;
	localparam logic [1:0] REG_LIMIT      = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_APPLY,
		S_HOLD
	} state_t;

	typedef struct packed {
		logic              valid;
		logic [MacW-1:0]   mac;
		logic [PortsW-1:0] ports;
		logic [1:0]        kind;
		logic [1:0]        cls;
		logic [StampW-1:0] stamp;
	} entry_t;

	typedef struct packed {
		logic [AgeW-1:0] normal_age;
		logic [AgeW-1:0] fast_age;
		logic            fast_on;
		logic [LimW-1:0] limit;
	} cfg_t;

	function automatic entry_t seed_entry();
		entry_t e;
		e       = '0;
		e.valid = 1'b1;
		e.mac   = StpMac;
		e.ports = {{(PortsW-1){1'b0}}, 1'b1};
		e.kind  = KIND_STATIC;
		e.cls   = CLASS_STP;
		return e;
	endfunction

endpackage
`default_nettype wire

/* src/mac_learning_table_aging.sv */
// mac_learning_table_aging: top level, ring of slot cells, sequencer and register port
// depends on mlta_pkg, mlta_cell, mlta_ctrl
//
//  channel | handshake           | payload
//  in      | in_valid / in_stall | op mac port_num port_set entry_kind entry_class now_seconds
//  out     | out_valid/out_stall | status found_ports found_class evicted
//  config  | apb write/read      | normal_age_limit fast_age_limit fast_aging_on entry_limit
//
// for each word the ring turns once to age, search and count,
// then once more to write the change at its slot
// reset leaves the static stp entry in slot 0 and all other slots empty, no clearing pass
// a finished word waits in the output register while the next word is taken
`default_nettype none
module mac_learning_table_aging #(
	parameter int TABLE_ENTRIES = mlta_pkg::TableEntriesDef,
	parameter int PORT_COUNT    = mlta_pkg::PortCountDef
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  op,
	input  wire logic [47:0] mac,
	input  wire logic [3:0]  port_num,
	input  wire logic [15:0] port_set,
	input  wire logic [1:0]  entry_kind,
	input  wire logic [1:0]  entry_class,
	input  wire logic [31:0] now_seconds,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic [15:0]      found_ports,
	output logic [1:0]       found_class,
	output logic             evicted,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import mlta_pkg::*;

	cfg_t   cfg_q;
	entry_t ring [TABLE_ENTRIES];
	entry_t wb;
	logic   shift;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.normal_age <= AgeW'(300);
			cfg_q.fast_age   <= AgeW'(5);
			cfg_q.fast_on    <= 1'b0;
			cfg_q.limit      <= LimW'(1024);
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_NORMAL_AGE: cfg_q.normal_age <= pwdata[AgeW-1:0];
				REG_FAST_AGE:   cfg_q.fast_age   <= pwdata[AgeW-1:0];
				REG_FAST_ON:    cfg_q.fast_on    <= pwdata[0];
				REG_LIMIT:      cfg_q.limit      <= pwdata[LimW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_NORMAL_AGE: prdata = {{(32-AgeW){1'b0}}, cfg_q.normal_age};
			REG_FAST_AGE:   prdata = {{(32-AgeW){1'b0}}, cfg_q.fast_age};
			REG_FAST_ON:    prdata = {31'b0, cfg_q.fast_on};
			REG_LIMIT:      prdata = {{(32-LimW){1'b0}}, cfg_q.limit};
			default:        prdata = '0;
		endcase
	end

	for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
		if (k == TABLE_ENTRIES - 1) begin : g_tail
			mlta_cell #(.SEED(k == 0)) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (shift),
				.d      (wb),
				.q      (ring[k])
			);
		end else begin : g_body
			mlta_cell #(.SEED(k == 0)) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (shift),
				.d      (ring[k+1]),
				.q      (ring[k])
			);
		end
	end

	mlta_ctrl #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.PORT_COUNT    (PORT_COUNT)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.mac         (mac),
		.port_num    (port_num),
		.port_set    (port_set),
		.entry_kind  (entry_kind),
		.entry_class (entry_class),
		.now_seconds (now_seconds),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.found_ports (found_ports),
		.found_class (found_class),
		.evicted     (evicted),
		.cfg         (cfg_q),
		.head        (ring[0]),
		.wb          (wb),
		.shift       (shift)
	);

endmodule
`default_nettype wire

/* src/mlta_cell.sv */
// mlta_cell: one table slot of the rotating ring
// depends on mlta_pkg
`default_nettype none
module mlta_cell #(
	parameter bit SEED = 1'b0
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                shift,
	input  wire mlta_pkg::entry_t    d,
	output mlta_pkg::entry_t         q
);
	import mlta_pkg::*;

	entry_t slot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= SEED ? seed_entry() : entry_t'('0);
		end else if (shift) begin
			slot_q <= d;
		end
	end

	assign q = slot_q;

endmodule
`default_nettype wire

/* src/mlta_ctrl.sv */
// mlta_ctrl: sequencer at the head of the ring, scans slots and applies updates
// depends on mlta_pkg
`default_nettype none
module mlta_ctrl #(
	parameter int TABLE_ENTRIES = mlta_pkg::TableEntriesDef,
	parameter int PORT_COUNT    = mlta_pkg::PortCountDef
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [2:0]         op,
	input  wire logic [47:0]        mac,
	input  wire logic [3:0]         port_num,
	input  wire logic [15:0]        port_set,
	input  wire logic [1:0]         entry_kind,
	input  wire logic [1:0]         entry_class,
	input  wire logic [31:0]        now_seconds,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [1:0]              status,
	output logic [15:0]             found_ports,
	output logic [1:0]              found_class,
	output logic                    evicted,
	input  wire mlta_pkg::cfg_t     cfg,
	input  wire mlta_pkg::entry_t   head,
	output mlta_pkg::entry_t        wb,
	output logic                    shift
);
	import mlta_pkg::*;

	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam int LW = (CW > LimW) ? CW : LimW;
	localparam logic [IW-1:0] LastIdx = IW'(TABLE_ENTRIES - 1);
	localparam logic [LW-1:0] FullLim = LW'(TABLE_ENTRIES);
	localparam logic [PortsW-1:0] PortMask =
		(PORT_COUNT >= PortsW) ? {PortsW{1'b1}} : PortsW'((1 << PORT_COUNT) - 1);

	state_t state_q, state_d;
	logic [IW-1:0] idx_q;

	op_t               op_q;
	logic [MacW-1:0]   mac_q;
	logic [PortsW-1:0] pbit_q, pset_q;
	logic [1:0]        kind_q, cls_q;
	logic [StampW-1:0] now_q;
	logic [AgeW-1:0]   age_q;

	logic              found_q;
	logic [IW-1:0]     s_q;
	logic [PortsW-1:0] f_ports_q;
	logic [1:0]        f_class_q, f_kind_q;
	logic [CW-1:0]     used_q;
	logic              old_has_q, free_has_q;
	logic [IW-1:0]     old_idx_q, free_idx_q;
	logic [StampW-1:0] old_stamp_q;

	logic [IW-1:0]     tgt_q;
	logic              ins_q, upd_q, kill_old_q;
	logic [1:0]        res_status_q, res_class_q;
	logic [PortsW-1:0] res_ports_q;
	logic              res_ev_q;

	logic              out_valid_q;
	logic [1:0]        status_q, class_q;
	logic [PortsW-1:0] ports_q;
	logic              ev_q;

	logic              aged, keep, hit, last, out_busy, done, load;
	logic [LW-1:0]     lim, used_w;
	logic              need_ins;
	entry_t            ins_e, upd_e;
	logic [PortsW-1:0] pbit_in;
	logic [1:0]        kind_in;

	logic [1:0]        dec_status, dec_class;
	logic [PortsW-1:0] dec_ports;
	logic              dec_ev, dec_ins, dec_upd, dec_kill;
	logic [IW-1:0]     dec_tgt;

	assign last     = (idx_q == LastIdx);
	assign out_busy = out_valid_q && out_stall;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (in_valid) state_d = S_SCAN;
			S_SCAN:   if (last) state_d = S_DECIDE;
			S_DECIDE: state_d = S_APPLY;
			S_APPLY:  if (last) state_d = out_busy ? S_HOLD : S_IDLE;
			S_HOLD:   if (!out_busy) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// fsm outputs
	always_comb begin
		in_stall = 1'b1;
		shift    = 1'b0;
		done     = 1'b0;
		unique case (state_q)
			S_IDLE:   in_stall = 1'b0;
			S_SCAN:   shift = 1'b1;
			S_DECIDE: ;
			S_APPLY: begin
				shift = 1'b1;
				done  = last;
			end
			S_HOLD:   done = 1'b1;
			default:  ;
		endcase
	end

	assign load = done && !out_busy;

	// head of the ring
	always_comb begin
		aged = head.valid && (head.kind != KIND_STATIC) &&
			(({1'b0, head.stamp} + {{(StampW+1-AgeW){1'b0}}, age_q}) <= {1'b0, now_q});
		keep = head.valid && !aged && !((op_q == OP_FLUSH) && (head.kind == KIND_DYN));
		hit  = keep && (head.mac == mac_q) && !found_q &&
			(op_q != OP_FLUSH) && (op_q != OP_NOP);

		ins_e       = '0;
		ins_e.valid = 1'b1;
		ins_e.mac   = mac_q;
		ins_e.stamp = now_q;
		unique case (op_q)
			OP_ADD: begin
				ins_e.ports = pbit_q;
				ins_e.kind  = kind_q;
				ins_e.cls   = cls_q;
			end
			OP_STATIC: begin
				ins_e.ports = pset_q;
				ins_e.kind  = KIND_STATIC;
			end
			default: ins_e.ports = pbit_q;
		endcase

		upd_e = head;
		unique case (op_q)
			OP_LEARN: begin
				upd_e.stamp = now_q;
				upd_e.ports = pbit_q;
			end
			OP_ADD: begin
				upd_e.stamp = now_q;
				if ((head.ports & pbit_q) != '0) upd_e.ports = pbit_q;
			end
			OP_STATIC: begin
				upd_e.stamp = now_q;
				upd_e.ports = head.ports | pset_q;
			end
			OP_REMOVE:  upd_e.valid = 1'b0;
			OP_RM_PORT: upd_e.ports = head.ports & ~pbit_q;
			default: ;
		endcase

		wb = head;
		if (state_q == S_SCAN) begin
			wb.valid = keep;
		end else if (ins_q && idx_q == tgt_q) begin
			wb = ins_e;
		end else if (upd_q && idx_q == tgt_q) begin
			wb = upd_e;
		end else if (kill_old_q && idx_q == old_idx_q) begin
			wb.valid = 1'b0;
		end
	end

	// insert, update and status decision
	always_comb begin
		lim = ((cfg.limit == '0) || (LW'(cfg.limit) > FullLim)) ? FullLim : LW'(cfg.limit);
		used_w   = LW'(used_q);
		need_ins = !found_q && ((op_q == OP_LEARN) || (op_q == OP_ADD) || (op_q == OP_STATIC));
		pbit_in  = (32'(port_num) < PORT_COUNT) ? (PortsW'(1) << port_num) : '0;
		kind_in  = (entry_kind == KIND_RSVD) ? KIND_GROUP : entry_kind;

		dec_status = ST_DONE;
		dec_ports  = '0;
		dec_class  = CLASS_NONE;
		dec_ev     = 1'b0;
		dec_ins    = 1'b0;
		dec_upd    = 1'b0;
		dec_kill   = 1'b0;
		dec_tgt    = s_q;
		if (need_ins) begin
			if (used_w > lim) begin
				dec_status = ST_FULL;
			end else if (used_w == lim) begin
				if (!old_has_q) begin
					dec_status = ST_FULL;
				end else begin
					dec_ev  = 1'b1;
					dec_ins = 1'b1;
					if (free_has_q && free_idx_q < old_idx_q) begin
						dec_tgt  = free_idx_q;
						dec_kill = 1'b1;
					end else begin
						dec_tgt = old_idx_q;
					end
				end
			end else begin
				dec_ins = 1'b1;
				dec_tgt = free_idx_q;
			end
		end else if (found_q) begin
			if (op_q == OP_LOOKUP) begin
				dec_ports = f_ports_q;
				dec_class = f_class_q;
			end
			dec_upd = (op_q != OP_LOOKUP) && !((op_q == OP_LEARN) && (f_kind_q != KIND_DYN));
		end else if ((op_q == OP_LOOKUP) || (op_q == OP_REMOVE) || (op_q == OP_RM_PORT)) begin
			dec_status = ST_MISSING;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (shift) idx_q <= last ? '0 : idx_q + IW'(1);
			if (load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			op_q        <= op_t'(op);
			mac_q       <= mac;
			pbit_q      <= pbit_in & PortMask;
			pset_q      <= port_set & PortMask;
			kind_q      <= kind_in;
			cls_q       <= entry_class;
			now_q       <= now_seconds;
			age_q       <= cfg.fast_on ? cfg.fast_age : cfg.normal_age;
			found_q     <= 1'b0;
			used_q      <= '0;
			old_has_q   <= 1'b0;
			free_has_q  <= 1'b0;
			ins_q       <= 1'b0;
			upd_q       <= 1'b0;
			kill_old_q  <= 1'b0;
		end
		if (state_q == S_SCAN) begin
			if (hit) begin
				found_q   <= 1'b1;
				s_q       <= idx_q;
				f_ports_q <= head.ports;
				f_class_q <= head.cls;
				f_kind_q  <= head.kind;
			end
			if (keep) used_q <= used_q + CW'(1);
			if (keep && head.kind == KIND_DYN && (!old_has_q || head.stamp < old_stamp_q)) begin
				old_has_q   <= 1'b1;
				old_idx_q   <= idx_q;
				old_stamp_q <= head.stamp;
			end
			if (!keep && !free_has_q) begin
				free_has_q <= 1'b1;
				free_idx_q <= idx_q;
			end
		end
		if (state_q == S_DECIDE) begin
			res_status_q <= dec_status;
			res_ports_q  <= dec_ports;
			res_class_q  <= dec_class;
			res_ev_q     <= dec_ev;
			tgt_q        <= dec_tgt;
			ins_q        <= dec_ins;
			upd_q        <= dec_upd;
			kill_old_q   <= dec_kill;
		end
		if (load) begin
			status_q <= res_status_q;
			ports_q  <= res_ports_q;
			class_q  <= res_class_q;
			ev_q     <= res_ev_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign found_ports = ports_q;
	assign found_class = class_q;
	assign evicted     = ev_q;

endmodule
`default_nettype wire

/* sim/tb.sv */
// tb: self-checking bench for mac_learning_table_aging, directed table then random phases
// depends on mlta_pkg and the mac_learning_table_aging rtl, predicts each untyped word in-bench
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import mlta_pkg::*;

	localparam int Slots = 1024;

	typedef struct {
		op_t         op;
		logic [47:0] mac;
		logic [3:0]  pnum;
		logic [15:0] pset;
		logic [1:0]  kind;
		logic [1:0]  cls;
		logic [31:0] now;
	} word_t;

	typedef struct {
		logic [1:0]  status;
		logic [15:0] ports;
		logic [1:0]  cls;
		logic        evicted;
	} reply_t;

	typedef struct {
		word_t  w;
		bit     typed;
		reply_t r;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] op = '0;
	logic [47:0] mac = '0;
	logic [3:0] port_num = '0;
	logic [15:0] port_set = '0;
	logic [1:0] entry_kind = '0;
	logic [1:0] entry_class = '0;
	logic [31:0] now_seconds = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] status;
	logic [15:0] found_ports;
	logic [1:0] found_class;
	logic evicted;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	mac_learning_table_aging i_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// table copy kept by the bench
	bit          t_valid[Slots];
	logic [47:0] t_mac[Slots];
	logic [15:0] t_ports[Slots];
	logic [1:0]  t_kind[Slots];
	logic [1:0]  t_cls[Slots];
	logic [31:0] t_stamp[Slots];
	logic [15:0] age_normal, age_fast;
	logic        fast_on;
	logic [10:0] entry_cap;

	reply_t replies_due[$];
	row_t rows[$];
	logic [47:0] mac_pool[12];
	int errors = 0;
	bit quiet = 0;
	bit hold_req = 0;
	logic [31:0] clock_s = 0;

	function automatic void table_reset();
		for (int i = 0; i < Slots; i++) begin
			t_valid[i] = 0; t_mac[i] = '0; t_ports[i] = '0;
			t_kind[i] = '0; t_cls[i] = '0; t_stamp[i] = '0;
		end
		t_valid[0] = 1; t_mac[0] = StpMac; t_ports[0] = 16'h0001;
		t_kind[0] = KIND_STATIC; t_cls[0] = CLASS_STP;
		age_normal = 16'd300; age_fast = 16'd5; fast_on = 0; entry_cap = 11'd1024;
	endfunction

	function automatic logic [1:0] table_insert(input logic [47:0] m, input logic [15:0] p,
			input logic [1:0] k, input logic [1:0] c, input logic [31:0] t, inout logic ev);
		int used, lim, oldest, free_i;
		used = 0; oldest = -1; free_i = -1;
		lim = (entry_cap == 0 || entry_cap > Slots) ? Slots : entry_cap;
		for (int i = 0; i < Slots; i++)
			if (t_valid[i]) begin
				used++;
				if (t_kind[i] == KIND_DYN && (oldest < 0 || t_stamp[i] < t_stamp[oldest]))
					oldest = i;
			end
		if (used > lim) return ST_FULL;
		if (used == lim) begin
			if (oldest < 0) return ST_FULL;
			t_valid[oldest] = 0;
			ev = 1'b1;
		end
		for (int i = 0; i < Slots; i++)
			if (!t_valid[i]) begin
				free_i = i;
				break;
			end
		if (free_i < 0) return ST_FULL;
		t_valid[free_i] = 1; t_mac[free_i] = m; t_ports[free_i] = p;
		t_kind[free_i] = k; t_cls[free_i] = c; t_stamp[free_i] = t;
		return ST_DONE;
	endfunction

	function automatic reply_t table_apply(input word_t w);
		reply_t r;
		logic [32:0] age;
		logic [15:0] pbit;
		logic [1:0] k;
		int s;
		r = '{ST_DONE, 16'h0, 2'h0, 1'b0};
		age = fast_on ? age_fast : age_normal;
		pbit = 16'h1 << w.pnum;
		k = (w.kind == KIND_RSVD) ? KIND_GROUP : w.kind;
		for (int i = 0; i < Slots; i++)
			if (t_valid[i] && t_kind[i] != KIND_STATIC && {1'b0, t_stamp[i]} + age <= {1'b0, w.now})
				t_valid[i] = 0;
		s = -1;
		if (w.op <= OP_RM_PORT)
			for (int i = 0; i < Slots; i++)
				if (t_valid[i] && t_mac[i] == w.mac) begin
					s = i;
					break;
				end
		case (w.op)
			OP_LEARN: begin
				if (s < 0) r.status = table_insert(w.mac, pbit, KIND_DYN, CLASS_NONE, w.now, r.evicted);
				else if (t_kind[s] == KIND_DYN) begin
					t_stamp[s] = w.now;
					t_ports[s] = pbit;
				end
			end
			OP_LOOKUP: begin
				if (s < 0) r.status = ST_MISSING;
				else begin
					r.ports = t_ports[s];
					r.cls = t_cls[s];
				end
			end
			OP_ADD: begin
				if (s < 0) r.status = table_insert(w.mac, pbit, k, w.cls, w.now, r.evicted);
				else begin
					t_stamp[s] = w.now;
					if ((t_ports[s] & pbit) != 0) t_ports[s] = pbit;
				end
			end
			OP_STATIC: begin
				if (s < 0) r.status = table_insert(w.mac, w.pset, KIND_STATIC, CLASS_NONE, w.now, r.evicted);
				else begin
					t_stamp[s] = w.now;
					t_ports[s] = t_ports[s] | w.pset;
				end
			end
			OP_REMOVE: begin
				if (s < 0) r.status = ST_MISSING;
				else t_valid[s] = 0;
			end
			OP_RM_PORT: begin
				if (s < 0) r.status = ST_MISSING;
				else t_ports[s] = t_ports[s] & ~pbit;
			end
			OP_FLUSH: begin
				for (int i = 0; i < Slots; i++)
					if (t_kind[i] == KIND_DYN) t_valid[i] = 0;
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic send_word(input word_t w, input bit typed, input reply_t r_typed);
		int gap;
		reply_t r;
		bit stalled;
		gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		op <= w.op; mac <= w.mac; port_num <= w.pnum; port_set <= w.pset;
		entry_kind <= w.kind; entry_class <= w.cls; now_seconds <= w.now;
		in_valid <= 1'b1;
		do begin
			@(negedge clk);
			stalled = in_stall;
			@(posedge clk);
		end while (stalled);
		r = table_apply(w);
		replies_due = {replies_due, (typed ? r_typed : r)};
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		in_valid <= 1'b0;
		wait (replies_due.size() == 0);
		@(posedge clk);
		repeat (2100) @(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			REG_NORMAL_AGE: age_normal = val[15:0];
			REG_FAST_AGE:   age_fast = val[15:0];
			REG_FAST_ON:    fast_on = val[0];
			default:        entry_cap = val[10:0];
		endcase
	endtask

	task automatic set_phase(input logic [15:0] na, input logic [15:0] fa, input logic fo,
			input logic [10:0] lim);
		write_reg(REG_NORMAL_AGE, {16'h0, na});
		write_reg(REG_FAST_AGE, {16'h0, fa});
		write_reg(REG_FAST_ON, {31'h0, fo});
		write_reg(REG_LIMIT, {21'h0, lim});
	endtask

	function automatic word_t random_word(input int step);
		word_t w;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 20) w.op = OP_LEARN;
		else if (pick < 38) w.op = OP_LOOKUP;
		else if (pick < 53) w.op = OP_ADD;
		else if (pick < 66) w.op = OP_STATIC;
		else if (pick < 80) w.op = OP_REMOVE;
		else if (pick < 93) w.op = OP_RM_PORT;
		else if (pick < 97) w.op = OP_FLUSH;
		else w.op = OP_NOP;
		w.mac = ($urandom_range(0, 4) == 0) ? 48'({$urandom, $urandom}) :
			mac_pool[$urandom_range(0, 11)];
		w.pnum = 4'($urandom_range(0, 15));
		w.pset = 16'($urandom);
		w.kind = 2'($urandom_range(0, 3));
		w.cls = 2'($urandom_range(0, 3));
		if ($urandom_range(0, 39) == 0) clock_s = $urandom;
		else clock_s = clock_s + $urandom_range(0, step);
		w.now = clock_s;
		return w;
	endfunction

	task automatic run_phase(input int count, input int step, input bit hold);
		reply_t none;
		none = '{ST_DONE, 16'h0, 2'h0, 1'b0};
		for (int n = 0; n < count; n++) begin
			if (hold && n == 5) hold_req = 1;
			send_word(random_word(step), 0, none);
		end
	endtask

	task automatic add_row(input op_t o, input logic [47:0] m, input logic [3:0] pn,
			input logic [15:0] ps, input logic [1:0] k, input logic [1:0] c, input logic [31:0] t,
			input bit typed, input logic [1:0] st, input logic [15:0] fp, input logic [1:0] fc);
		row_t x;
		x.w = '{o, m, pn, ps, k, c, t};
		x.typed = typed;
		x.r = '{st, fp, fc, 1'b0};
		rows = {rows, x};
	endtask

	// receiver stall: random bursts, one long hold, none in the quiet part
	int burst_left = 0;
	int hold_left = 0;
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req = 0;
			hold_left = 6000;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (burst_left > 0) begin
			burst_left--;
			out_stall <= 1'b1;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			burst_left = $urandom_range(0, 5);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(negedge clk) begin
		reply_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (replies_due.size() == 0) begin
				$display("%0t: unexpected word status %0d ports %h", $realtime, status, found_ports);
				errors++;
			end else begin
				e = replies_due.pop_front();
				if (status !== e.status) begin
					$display("%0t: status expected %0d actual %0d", $realtime, e.status, status);
					errors++;
				end
				if (found_ports !== e.ports) begin
					$display("%0t: found_ports expected %h actual %h", $realtime, e.ports, found_ports);
					errors++;
				end
				if (found_class !== e.cls) begin
					$display("%0t: found_class expected %0d actual %0d", $realtime, e.cls, found_class);
					errors++;
				end
				if (evicted !== e.evicted) begin
					$display("%0t: evicted expected %0d actual %0d", $realtime, e.evicted, evicted);
					errors++;
				end
			end
		end
	end

	initial begin
		#(64'd80_000_000);
		$display("simulation failed");
		$finish;
	end

	initial begin
		table_reset();
		mac_pool[0] = StpMac;
		for (int i = 1; i < 12; i++) mac_pool[i] = 48'({$urandom, $urandom});
		add_row(OP_LOOKUP, StpMac, 0, 0, 0, 0, 0, 1, ST_DONE, 16'h0001, CLASS_STP);
		add_row(OP_LOOKUP, 48'h0, 0, 0, 0, 0, 0, 1, ST_MISSING, 0, 0);
		add_row(OP_LEARN, 48'hFFFF_FFFF_FFFF, 15, 0, 0, 0, 10, 0, 0, 0, 0);
		add_row(OP_LOOKUP, 48'hFFFF_FFFF_FFFF, 0, 0, 0, 0, 10, 1, ST_DONE, 16'h8000, CLASS_NONE);
		add_row(OP_ADD, 48'h1, 0, 0, KIND_RSVD, 2'd3, 11, 0, 0, 0, 0);
		add_row(OP_LOOKUP, 48'h1, 0, 0, 0, 0, 11, 0, 0, 0, 0);
		add_row(OP_ADD, 48'h1, 0, 0, KIND_DYN, 0, 11, 0, 0, 0, 0);
		add_row(OP_STATIC, 48'h2, 0, 16'hFFFF, 0, 0, 11, 0, 0, 0, 0);
		add_row(OP_STATIC, StpMac, 0, 16'h00F0, 0, 0, 11, 0, 0, 0, 0);
		add_row(OP_LOOKUP, StpMac, 0, 0, 0, 0, 11, 0, 0, 0, 0);
		add_row(OP_LEARN, StpMac, 3, 0, 0, 0, 11, 0, 0, 0, 0);
		add_row(OP_RM_PORT, 48'h2, 15, 0, 0, 0, 11, 0, 0, 0, 0);
		add_row(OP_LOOKUP, 48'h2, 0, 0, 0, 0, 11, 0, 0, 0, 0);
		add_row(OP_RM_PORT, 48'h123, 1, 0, 0, 0, 11, 1, ST_MISSING, 0, 0);
		add_row(OP_REMOVE, 48'h123, 0, 0, 0, 0, 11, 1, ST_MISSING, 0, 0);
		add_row(OP_REMOVE, 48'h1, 0, 0, 0, 0, 11, 0, 0, 0, 0);
		add_row(OP_LOOKUP, 48'h1, 0, 0, 0, 0, 11, 1, ST_MISSING, 0, 0);
		add_row(OP_ADD, 48'h3, 7, 0, KIND_DYN, CLASS_STP, 12, 0, 0, 0, 0);
		add_row(OP_FLUSH, 48'h0, 0, 0, 0, 0, 12, 0, 0, 0, 0);
		add_row(OP_LOOKUP, 48'h3, 0, 0, 0, 0, 12, 1, ST_MISSING, 0, 0);
		add_row(OP_LEARN, 48'h4, 2, 0, 0, 0, 100, 0, 0, 0, 0);
		add_row(OP_LOOKUP, 48'h4, 0, 0, 0, 0, 400, 1, ST_MISSING, 0, 0);
		add_row(OP_NOP, 48'h4, 0, 0, 0, 0, 401, 1, ST_DONE, 0, 0);
		add_row(OP_LEARN, 48'h5, 9, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(OP_LOOKUP, 48'h5, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].r);
		set_phase(16'd300, 16'd5, 1'b0, 11'd6);
		run_phase(110, 20, 0);
		write_reg(REG_LIMIT, 32'd3);
		run_phase(40, 10, 0);
		set_phase(16'd65535, 16'd3, 1'b1, 11'd0);
		run_phase(100, 4, 0);
		set_phase(16'd0, 16'd65535, 1'b0, 11'd2047);
		run_phase(60, 3, 0);
		set_phase(16'd65535, 16'd0, 1'b0, 11'd1024);
		run_phase(100, 3, 1);
		set_phase(16'd20, 16'd5, 1'b0, 11'd1);
		quiet = 1;
		run_phase(150, 8, 0);
		@(posedge clk);
		in_valid <= 1'b0;
		wait (replies_due.size() == 0);
		repeat (2100) @(posedge clk);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
`default_nettype wire
